@@ sv/dots_pkg.sv @@
package dots_pkg;

   // Sizing of the ready list and of the stored task identifiers.
   localparam int LIST_DEPTH   = 16;
   localparam int TASK_ID_BITS = 8;
   localparam int KEY_W        = 17;
   localparam int COUNT_W      = $clog2(LIST_DEPTH + 1);

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [TASK_ID_BITS-1:0] tid_type;
   typedef logic [COUNT_W-1:0]      count_type;

   // Most negative key; aging stops here.
   localparam key_type KEY_MIN = {1'b1, {(KEY_W - 1){1'b0}}};

   // Item kinds on the request channel.
   typedef enum logic {
      MODE_LOAD = 1'b0,
      MODE_TICK = 1'b1
   } mode_type;

   // Result codes on the response channel.
   typedef enum logic [1:0] {
      STATUS_ACCEPT   = 2'd0,
      STATUS_DROP     = 2'd1,
      STATUS_DISPATCH = 2'd2,
      STATUS_IDLE     = 2'd3
   } status_type;

   // Operation that every cell of the ready list performs.
   typedef enum logic [2:0] {
      OP_HOLD    = 3'd0,
      OP_AGE     = 3'd1,
      OP_INSERT  = 3'd2,
      OP_SHIFT   = 3'd3,
      OP_REQUEUE = 3'd4
   } cell_op_type;

   // Control that the top level hands to one cell.
   typedef struct packed {
      cell_op_type op;
      logic        occ;       // this cell holds a live entry
      logic        occ_next;  // the right neighbor holds a live entry
      key_type     new_key;
      tid_type     new_tid;
   } cell_ctl_type;

   typedef struct packed {
      logic        mode;
      logic [7:0]  task_id;
      logic [15:0] task_period;
      logic        exit_flag;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] next_task;
   } rsp_type;

   // Decrement by one, saturating at the lowest key.
   function automatic key_type age_key(key_type k);
      return (k == KEY_MIN) ? k : key_type'(k - key_type'(1));
   endfunction

endpackage

@@ sv/dots_cell.sv @@
module dots_cell (
   input  logic                  clock,
   input  dots_pkg::cell_ctl_type ctl,
   input  dots_pkg::key_type     left_key,
   input  dots_pkg::tid_type     left_tid,
   input  logic                  left_ge,
   input  dots_pkg::key_type     right_key,
   input  dots_pkg::tid_type     right_tid,
   output dots_pkg::key_type     key,
   output dots_pkg::tid_type     tid,
   output logic                  ge
);
   import dots_pkg::*;

   key_type key_ff, key_in;
   tid_type tid_ff, tid_in;

   // The insertion point lies at or before this slot when the slot is free or its key
   // is strictly larger; equal keys stay in front of the new entry.
   always_comb begin
      case (ctl.op)
         OP_INSERT:  ge = !ctl.occ || (key_ff > ctl.new_key);
         OP_REQUEUE: ge = !ctl.occ_next || (right_key > ctl.new_key);
         default:    ge = 1'b0;
      endcase
   end

   // Next contents of the slot, taken from itself, a neighbor or the broadcast entry.
   always_comb begin
      key_in = key_ff;
      tid_in = tid_ff;
      case (ctl.op)
         OP_AGE: begin
            key_in = age_key(key_ff);
         end
         OP_INSERT: begin
            if (ge && left_ge) begin
               key_in = left_key;
               tid_in = left_tid;
            end else if (ge) begin
               key_in = ctl.new_key;
               tid_in = ctl.new_tid;
            end
         end
         OP_SHIFT: begin
            key_in = right_key;
            tid_in = right_tid;
         end
         OP_REQUEUE: begin
            // The head leaves, so the list as seen here is shifted left by one.
            if (!ge) begin
               key_in = right_key;
               tid_in = right_tid;
            end else if (!left_ge) begin
               key_in = ctl.new_key;
               tid_in = ctl.new_tid;
            end
         end
         default: begin
            key_in = key_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tid_ff <= tid_in;
   end

   assign key = key_ff;
   assign tid = tid_ff;

endmodule

@@ sv/deadline_ordered_task_scheduler.sv @@
// Preemptive earliest-deadline-first scheduler for one processor. A load item
// inserts a task into a sorted ready list of LIST_DEPTH cells (behind equal keys)
// and answers in the cycle after its transfer; a load into a full list is dropped
// with status 1. A tick item first ages every key and the running task's remaining
// time, then in ST_EXEC dispatches, preempts or keeps the running task, or goes
// idle with an empty list, and writes the result. The list is a row of cells that
// shift entries to their neighbors. The block works on one item at a time; the
// next transfer is taken in ST_IDLE once the result register is free, so loads
// sustain one item every cycle while the receiver does not stall, and a tick holds
// off the next transfer until ST_EXEC is done.
module deadline_ordered_task_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dots_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dots_pkg::rsp_type rsp
);
   import dots_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type    state_ff, state_in;
   count_type    count_ff, count_in;
   tid_type      run_tid_ff, run_tid_in;
   key_type      run_rem_ff, run_rem_in;
   logic         run_valid_ff, run_valid_in;
   logic         exit_ff, exit_in;
   rsp_type      rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   cell_op_type  op;
   key_type      new_key;
   tid_type      new_tid;
   logic         req_take;
   logic         full;
   logic         preempt;

   key_type      cell_key [LIST_DEPTH];
   tid_type      cell_tid [LIST_DEPTH];
   logic         cell_ge  [LIST_DEPTH];
   cell_ctl_type cell_ctl [LIST_DEPTH];

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;
   assign full      = (count_ff == count_type'(LIST_DEPTH));
   assign preempt   = (count_ff != '0) && (cell_key[0] < run_rem_ff);

   // Sequencing of one item and the scheduling decision.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      run_tid_in   = run_tid_ff;
      run_rem_in   = run_rem_ff;
      run_valid_in = run_valid_ff;
      exit_in      = exit_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      op           = OP_HOLD;
      new_key      = run_rem_ff;
      new_tid      = run_tid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req.mode == MODE_TICK)) begin
               op         = OP_AGE;
               run_rem_in = age_key(run_rem_ff);
               exit_in    = req.exit_flag;
               state_in   = ST_EXEC;
            end else if (req_take) begin
               rsp_valid_in     = 1'b1;
               rsp_in.next_task = '0;
               if (full) begin
                  rsp_in.status = STATUS_DROP;
               end else begin
                  op            = OP_INSERT;
                  new_key       = key_type'({1'b0, req.task_period});
                  new_tid       = req.task_id[TASK_ID_BITS-1:0];
                  count_in      = count_ff + count_type'(1);
                  rsp_in.status = STATUS_ACCEPT;
               end
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (exit_ff || !run_valid_ff) begin
               if (count_ff == '0) begin
                  run_valid_in     = 1'b0;
                  rsp_in.status    = STATUS_IDLE;
                  rsp_in.next_task = '0;
               end else begin
                  op               = OP_SHIFT;
                  run_tid_in       = cell_tid[0];
                  run_rem_in       = cell_key[0];
                  run_valid_in     = 1'b1;
                  count_in         = count_ff - count_type'(1);
                  rsp_in.status    = STATUS_DISPATCH;
                  rsp_in.next_task = 8'(cell_tid[0]);
               end
            end else if (preempt) begin
               // The head takes over; the running task goes back into the list.
               op               = OP_REQUEUE;
               run_tid_in       = cell_tid[0];
               run_rem_in       = cell_key[0];
               rsp_in.status    = STATUS_DISPATCH;
               rsp_in.next_task = 8'(cell_tid[0]);
            end else begin
               rsp_in.status    = STATUS_DISPATCH;
               rsp_in.next_task = 8'(run_tid_ff);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Row of list cells, each linked to both neighbors.
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      key_type left_key, right_key;
      tid_type left_tid, right_tid;
      logic    left_ge;

      assign cell_ctl[i].op       = op;
      assign cell_ctl[i].occ      = count_ff > count_type'(i);
      assign cell_ctl[i].occ_next = count_ff > count_type'(i + 1);
      assign cell_ctl[i].new_key  = new_key;
      assign cell_ctl[i].new_tid  = new_tid;

      if (i == 0) begin : g_first
         assign left_key = '0;
         assign left_tid = '0;
         assign left_ge  = 1'b0;
      end else begin : g_inner_left
         assign left_key = cell_key[i-1];
         assign left_tid = cell_tid[i-1];
         assign left_ge  = cell_ge[i-1];
      end

      if (i == LIST_DEPTH - 1) begin : g_last
         assign right_key = '0;
         assign right_tid = '0;
      end else begin : g_inner_right
         assign right_key = cell_key[i+1];
         assign right_tid = cell_tid[i+1];
      end

      dots_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[i]),
         .left_key  (left_key),
         .left_tid  (left_tid),
         .left_ge   (left_ge),
         .right_key (right_key),
         .right_tid (right_tid),
         .key       (cell_key[i]),
         .tid       (cell_tid[i]),
         .ge        (cell_ge[i])
      );
   end

   // Control and running-task registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         run_tid_ff   <= '0;
         run_rem_ff   <= '0;
         run_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         run_tid_ff   <= run_tid_in;
         run_rem_ff   <= run_rem_in;
         run_valid_ff <= run_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      exit_ff <= exit_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ sv/dots_checker.sv @@
module dots_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input dots_pkg::req_type req,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input dots_pkg::rsp_type rsp
);
   import dots_pkg::*;

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled result changed or vanished");

   // A load transfer answers in the next cycle with a load status.
   a_load_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req.mode == MODE_LOAD) |=>
         rsp_valid && ((rsp.status == STATUS_ACCEPT) || (rsp.status == STATUS_DROP)))
      else $error("load transfer without a load result");

   // A tick transfer answers with a dispatch or idle status.
   a_tick_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req.mode == MODE_TICK) |=> ##1
         rsp_valid && ((rsp.status == STATUS_DISPATCH) || (rsp.status == STATUS_IDLE)))
      else $error("tick transfer without a scheduling result");

   // Only a dispatch names a task.
   a_task_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status != STATUS_DISPATCH) |-> (rsp.next_task == '0))
      else $error("task reported without a dispatch");

   // Nothing is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind deadline_ordered_task_scheduler dots_checker u_dots_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

@@ bench/deadline_ordered_task_scheduler_test.sv @@
`timescale 1ns / 100ps

// Tracks the ready list and the running task, and queues the result due for every
// transfer on the request channel.
class scheduler_scoreboard;
   dots_pkg::key_type ready_key [dots_pkg::LIST_DEPTH];
   dots_pkg::tid_type ready_tid [dots_pkg::LIST_DEPTH];
   int unsigned       ready_fill;
   dots_pkg::tid_type active_tid;
   logic              active_busy;
   dots_pkg::key_type active_left;
   dots_pkg::rsp_type awaited [$];
   int unsigned       mismatches;

   function new();
      ready_fill  = 0;
      active_tid  = '0;
      active_busy = 1'b0;
      active_left = '0;
      mismatches  = 0;
   endfunction

   // One tick of aging; the most negative key stays where it is.
   function dots_pkg::key_type aged(dots_pkg::key_type k);
      if (k != dots_pkg::KEY_MIN) begin
         k = dots_pkg::key_type'(k - 1);
      end
      return k;
   endfunction

   // Sorted insertion that places a new entry behind all equal keys.
   function void enqueue(dots_pkg::key_type k, dots_pkg::tid_type t);
      int unsigned pos;
      pos = 0;
      while (pos < ready_fill && ready_key[pos] <= k) begin
         pos++;
      end
      for (int unsigned i = ready_fill; i > pos; i--) begin
         ready_key[i] = ready_key[i - 1];
         ready_tid[i] = ready_tid[i - 1];
      end
      ready_key[pos] = k;
      ready_tid[pos] = t;
      ready_fill++;
   endfunction

   // Removes the head of the ready list and closes the gap.
   function void take_head(output dots_pkg::key_type k, output dots_pkg::tid_type t);
      k = ready_key[0];
      t = ready_tid[0];
      for (int unsigned i = 1; i < ready_fill; i++) begin
         ready_key[i - 1] = ready_key[i];
         ready_tid[i - 1] = ready_tid[i];
      end
      ready_fill--;
   endfunction

   function void note_request(dots_pkg::req_type item);
      dots_pkg::rsp_type outcome;
      dots_pkg::key_type head_key;
      dots_pkg::tid_type head_tid;
      outcome = '0;
      if (item.mode == dots_pkg::MODE_LOAD) begin
         // A load either lands in the list or is dropped when it is full.
         if (ready_fill >= dots_pkg::LIST_DEPTH) begin
            outcome.status = dots_pkg::STATUS_DROP;
         end else begin
            enqueue(dots_pkg::key_type'({1'b0, item.task_period}),
                    item.task_id[dots_pkg::TASK_ID_BITS-1:0]);
            outcome.status = dots_pkg::STATUS_ACCEPT;
         end
      end else begin
         // A tick ages everything first, then picks what runs next.
         for (int unsigned i = 0; i < ready_fill; i++) begin
            ready_key[i] = aged(ready_key[i]);
         end
         active_left    = aged(active_left);
         outcome.status = dots_pkg::STATUS_DISPATCH;
         if (item.exit_flag || !active_busy) begin
            if (ready_fill == 0) begin
               active_busy    = 1'b0;
               outcome.status = dots_pkg::STATUS_IDLE;
            end else begin
               take_head(active_left, active_tid);
               active_busy = 1'b1;
            end
         end else if (ready_fill != 0 && ready_key[0] < active_left) begin
            // Preemption: the running task goes back into the list.
            take_head(head_key, head_tid);
            enqueue(active_left, active_tid);
            active_left = head_key;
            active_tid  = head_tid;
         end
         if (outcome.status == dots_pkg::STATUS_DISPATCH) begin
            outcome.next_task = 8'(active_tid);
         end
      end
      awaited.insert(awaited.size(), outcome);
   endfunction

   function void check_response(dots_pkg::rsp_type got);
      dots_pkg::rsp_type want;
      if (awaited.size() == 0) begin
         $error("result with no item outstanding: status %0d next_task %0d",
                got.status, got.next_task);
         mismatches++;
      end else begin
         want = awaited[0];
         awaited.delete(0);
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
         end
         if (got.next_task !== want.next_task) begin
            $error("next_task: expected %0d, got %0d", want.next_task, got.next_task);
            mismatches++;
         end
      end
   endfunction

   function int unsigned pending();
      return awaited.size();
   endfunction
endclass

module deadline_ordered_task_scheduler_test;
   import dots_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RANDOM_ITEMS = 400;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 2_000_000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   scheduler_scoreboard board = new();

   int unsigned hold_asks   = 0;
   int unsigned hold_served = 0;
   bit          bursty      = 1'b1;
   int unsigned burst_left  = 0;

   always #HALF_PERIOD clock = ~clock;

   deadline_ordered_task_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   function automatic req_type build(mode_type m, logic [7:0] id, logic [15:0] period,
                                     logic leave);
      req_type r;
      r.mode        = m;
      r.task_id     = id;
      r.task_period = period;
      r.exit_flag   = leave;
      return r;
   endfunction

   // Periods lean toward small values so that ties and preemptions are common.
   function automatic logic [15:0] pick_period();
      logic [15:0] p;
      case ($urandom_range(0, 9))
         0:       p = 16'h0000;
         1:       p = 16'hFFFF;
         2, 3, 4, 5: p = 16'($urandom_range(0, 24));
         default: p = 16'($urandom);
      endcase
      return p;
   endfunction

   // Offers one item and waits for its transfer; gaps fall between bursts.
   task offer(input req_type item);
      int unsigned gap;
      if (bursty && burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req       <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      board.note_request(item);
      if (burst_left != 0) begin
         burst_left--;
      end
   endtask

   // Stops offering until every expected result has come back.
   task drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // Every result transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_response(rsp);
      end
   end

   // Receiver stalls: free runs, random stalls of two densities, short solid stalls,
   // and a long hold whenever the stimulus asks for one.
   initial begin : rsp_pattern
      int unsigned kind;
      int unsigned span;
      kind = 0;
      span = 0;
      forever begin
         if (hold_asks != hold_served) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_served++;
            span = 0;
         end else begin
            if (span == 0) begin
               kind = $urandom_range(0, 3);
               span = (kind == 3) ? $urandom_range(1, 8) : $urandom_range(1, 40);
            end
            case (kind)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 1) == 1);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= 1'b1;
            endcase
            span--;
            @(posedge clock);
         end
      end
   end

   // Watchdog on the total run length.
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int unsigned sent;
      int unsigned span;
      int unsigned seg;
      logic        is_tick;
      logic        leave;
      bit          held;
      bit          paused;
      sent   = 0;
      held   = 1'b0;
      paused = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Idle processor with an empty list, with and without an exit.
      offer(build(MODE_TICK, 8'h00, 16'h0000, 1'b0));
      offer(build(MODE_TICK, 8'hFF, 16'hFFFF, 1'b1));
      // Field extremes on loads, including a period of zero.
      offer(build(MODE_LOAD, 8'hFF, 16'hFFFF, 1'b1));
      offer(build(MODE_LOAD, 8'h00, 16'h0000, 1'b0));
      // Dispatch from idle takes the head and its key.
      offer(build(MODE_TICK, 8'h00, 16'h0000, 1'b0));
      // Two equal keys; the second goes behind the first.
      offer(build(MODE_LOAD, 8'h5A, 16'h0001, 1'b0));
      offer(build(MODE_LOAD, 8'hA5, 16'h0001, 1'b1));
      // Running task has the smaller remaining time, so it is kept.
      offer(build(MODE_TICK, 8'h00, 16'h0000, 1'b0));
      // Exits walk down the list in order.
      offer(build(MODE_TICK, 8'h00, 16'h0000, 1'b1));
      offer(build(MODE_TICK, 8'h00, 16'h0000, 1'b1));
      offer(build(MODE_TICK, 8'h00, 16'h0000, 1'b1));
      // Empty list while running: keep the running task.
      offer(build(MODE_TICK, 8'h00, 16'h0000, 1'b0));
      // A short deadline preempts the long-running task.
      offer(build(MODE_LOAD, 8'h77, 16'h0005, 1'b0));
      offer(build(MODE_TICK, 8'h00, 16'h0000, 1'b0));
      offer(build(MODE_TICK, 8'h00, 16'h0000, 1'b1));
      // Exit with an empty list goes idle.
      offer(build(MODE_TICK, 8'h00, 16'h0000, 1'b1));
      // Exit while idle with a waiting task dispatches it.
      offer(build(MODE_LOAD, 8'h12, 16'h0009, 1'b0));
      offer(build(MODE_TICK, 8'h00, 16'h0000, 1'b1));

      // Random segments: load-heavy fills (and overflows) the list, tick-heavy
      // runs age and preempt, mixed, and exit runs that empty it again.
      while (sent < RANDOM_ITEMS) begin
         seg  = $urandom_range(0, 3);
         span = $urandom_range(5, 30);
         for (int unsigned j = 0; j < span; j++) begin
            case (seg)
               0:       is_tick = ($urandom_range(0, 7) == 0);
               1:       is_tick = ($urandom_range(0, 5) != 0);
               2:       is_tick = 1'($urandom_range(0, 1));
               default: is_tick = 1'b1;
            endcase
            leave = (seg == 3) ? 1'b1 : ($urandom_range(0, 3) == 0);
            offer(build(is_tick ? MODE_TICK : MODE_LOAD, 8'($urandom_range(0, 255)),
                        pick_period(), leave));
            sent++;
            // Long receiver hold while the sender keeps offering.
            if (!held && sent >= RANDOM_ITEMS / 3) begin
               hold_asks++;
               held = 1'b1;
            end
            // One full pause until nothing is outstanding.
            if (!paused && sent >= (2 * RANDOM_ITEMS) / 3) begin
               drain();
               paused = 1'b1;
            end
         end
      end

      // Empty the list and go idle, then run tasks loaded with a zero period so
      // that list keys and the remaining time turn negative.
      bursty = 1'b0;
      for (int unsigned j = 0; j <= LIST_DEPTH; j++) begin
         offer(build(MODE_TICK, 8'($urandom_range(0, 255)), pick_period(), 1'b1));
      end
      offer(build(MODE_LOAD, 8'hC3, 16'h0000, 1'b0));
      offer(build(MODE_TICK, 8'h00, 16'h0000, 1'b0));
      offer(build(MODE_LOAD, 8'h3C, 16'h0000, 1'b1));
      offer(build(MODE_TICK, 8'h00, 16'h0000, 1'b0));
      offer(build(MODE_TICK, 8'h00, 16'h0000, 1'b1));
      offer(build(MODE_LOAD, 8'h81, 16'h0000, 1'b0));
      offer(build(MODE_TICK, 8'h00, 16'h0000, 1'b0));
      offer(build(MODE_TICK, 8'h00, 16'h0000, 1'b1));
      offer(build(MODE_TICK, 8'h00, 16'h0000, 1'b1));

      drain();
      repeat (8) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/dots_pkg.sv
sv/dots_cell.sv
sv/deadline_ordered_task_scheduler.sv
sv/dots_checker.sv
bench/deadline_ordered_task_scheduler_test.sv
